FILE: hw/rtl/ade_pkg.sv
package ade_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 64;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_DUMP       = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_PUSH_BACK,
        OP_PUSH_FRONT,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_DUMP
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT
    } back_state_t;

endpackage

FILE: hw/rtl/ade_front.sv
module ade_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  ade_pkg::req_t cmd_data,
    output logic          enq,
    output ade_pkg::cmd_t enq_cmd,
    input  logic          q_full
);
    import ade_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;
    logic code_ok;
    op_t  op_dec;

    always_comb
    begin
        code_ok = 1'b1;
        op_dec  = OP_PUSH_BACK;
        case (cmd_data.action)
            ACT_PUSH_BACK:  op_dec = OP_PUSH_BACK;
            ACT_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
            ACT_POP_FRONT:  op_dec = OP_POP_FRONT;
            ACT_POP_BACK:   op_dec = OP_POP_BACK;
            ACT_DUMP:       op_dec = OP_DUMP;
            default:        code_ok = 1'b0;
        endcase
    end

    assign cmd_stall = valid_reg && q_full;
    assign accept    = cmd_valid && !cmd_stall;
    assign enq       = valid_reg && !q_full;
    assign enq_cmd   = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg && q_full;
        cmd_next   = cmd_reg;
        if (accept)
        begin
            // unused codes are dropped here
            valid_next     = code_ok;
            cmd_next.op    = op_dec;
            cmd_next.value = cmd_data.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

FILE: hw/rtl/ade_cmd_queue.sv
module ade_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          enq,
    input  ade_pkg::cmd_t enq_cmd,
    output logic          full,
    output logic          deq_valid,
    output ade_pkg::cmd_t deq_cmd,
    input  logic          deq
);
    import ade_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_enq;
    logic             do_deq;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign deq_valid = count_reg != '0;
    assign deq_cmd   = entry_reg[rd_ptr_reg];
    assign do_enq    = enq && !full;
    assign do_deq    = deq && deq_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_enq)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_deq)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_enq && !do_deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_deq && !do_enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_enq)
        begin
            entry_reg[wr_ptr_reg] <= enq_cmd;
        end
    end

endmodule

FILE: hw/rtl/ade_back.sv
module ade_back #(
    parameter int DEPTH = ade_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  ade_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ade_pkg::rsp_t rsp_data
);
    import ade_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] RESET_IDX = CNT_W'(DEPTH / 2 + 1);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    back_state_t      state_reg;
    back_state_t      state_next;
    // head is the first stored slot, tail_end is one past the last
    logic [CNT_W-1:0] head_reg;
    logic [CNT_W-1:0] head_next;
    logic [CNT_W-1:0] tail_end_reg;
    logic [CNT_W-1:0] tail_end_next;
    logic [IDX_W-1:0] ptr_reg;
    logic [IDX_W-1:0] ptr_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    rsp_t             out_reg;
    rsp_t             out_next;

    logic             empty;
    logic             slot_free;
    logic             dump_last;
    logic [CNT_W-1:0] ptr_ext;
    logic             load;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;

    assign empty     = head_reg >= tail_end_reg;
    assign slot_free = !out_valid_reg || !rsp_stall;
    assign ptr_ext   = CNT_W'(ptr_reg) + CNT_W'(1);
    assign dump_last = ptr_ext == tail_end_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && slot_free && q_cmd.op == OP_DUMP && !empty)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = dump_last ? BK_IDLE : BK_READ;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        load           = 1'b0;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = tail_end_reg[IDX_W-1:0];
        head_next      = head_reg;
        tail_end_next  = tail_end_reg;
        ptr_next       = ptr_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop            = 1'b1;
                    load             = 1'b1;
                    out_next.status  = ST_OK;
                    out_next.element = '0;
                    out_next.last    = 1'b1;
                    case (q_cmd.op)
                        OP_PUSH_BACK:
                        begin
                            if (tail_end_reg == CNT_W'(DEPTH))
                            begin
                                out_next.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                mem_we        = 1'b1;
                                mem_waddr     = tail_end_reg[IDX_W-1:0];
                                tail_end_next = tail_end_reg + 1'b1;
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            if (head_reg == '0)
                            begin
                                out_next.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                head_next = head_reg - 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = head_next[IDX_W-1:0];
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                out_next.status = ST_UNDERFLOW;
                            end
                            else
                            begin
                                head_next = head_reg + 1'b1;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                out_next.status = ST_UNDERFLOW;
                            end
                            else
                            begin
                                tail_end_next = tail_end_reg - 1'b1;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (empty)
                            begin
                                out_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                q_pop    = 1'b0;
                                load     = 1'b0;
                                ptr_next = head_reg[IDX_W-1:0];
                            end
                        end
                        default:
                        begin
                            out_next.status = ST_OK;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                load = 1'b0;
            end
            BK_EMIT:
            begin
                if (slot_free)
                begin
                    load             = 1'b1;
                    out_next.status  = ST_OK;
                    out_next.element = rd_data_reg;
                    out_next.last    = dump_last;
                    if (dump_last)
                    begin
                        q_pop = 1'b1;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    assign out_valid_next = load || (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            head_reg      <= RESET_IDX;
            tail_end_reg  <= RESET_IDX;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_end_reg  <= tail_end_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= q_cmd.value;
        end
        rd_data_reg <= mem[ptr_reg];
    end

endmodule

FILE: hw/rtl/array_double_ended_queue.sv
// input to result path: front register, then command queue, then result register
// push and pop: taken in the back-end idle state when the result slot is free, one result per transfer
// dump: starts at the head, then each stored word is read from the store, then loaded into the result register
// input stalls only when the two-entry command queue and the front register are full
// reset (rst_n, async): queue empty, head and tail_end at DEPTH/2+1; store is not cleared
module array_double_ended_queue #(
    parameter int DEPTH = ade_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  ade_pkg::req_t cmd_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ade_pkg::rsp_t rsp_data
);
    import ade_pkg::*;

    logic enq;
    cmd_t enq_cmd;
    logic q_full;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    ade_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .enq       (enq),
        .enq_cmd   (enq_cmd),
        .q_full    (q_full)
    );

    ade_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq       (enq),
        .enq_cmd   (enq_cmd),
        .full      (q_full),
        .deq_valid (q_valid),
        .deq_cmd   (q_cmd),
        .deq       (q_pop)
    );

    ade_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

FILE: tb/array_double_ended_queue_test.sv
module array_double_ended_queue_test;

    import ade_pkg::*;

    localparam int DEPTH           = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 24;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int MAX_REPORTS     = 10;

    // action codes that the block ignores
    localparam logic [2:0] ACT_RSVD_A = 3'd5;
    localparam logic [2:0] ACT_RSVD_B = 3'd6;
    localparam logic [2:0] ACT_RSVD_C = 3'd7;

    typedef struct {
        req_t req;
        bit   fixed;
        rsp_t rsp;
    } row_t;

    logic clk;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    req_t cmd_data  = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    int send_idle  = 0;
    int recv_idle  = 0;
    int mismatches = 0;
    int cycles     = 0;
    int sent;

    bit   row_fixed = 1'b0;
    rsp_t row_rsp   = '0;
    rsp_t want;
    row_t rows[$];

    // mirror of the deque contents
    logic signed [DATA_W-1:0] words [DEPTH];
    int   front_idx;
    int   rear_idx;
    rsp_t due_rsp[$];

    array_double_ended_queue #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void step_deque(input req_t r);
        rsp_t o;
        o        = '0;
        o.status = ST_OK;
        o.last   = 1'b1;
        case (r.action)
            ACT_PUSH_BACK:
            begin
                if (rear_idx >= DEPTH - 1)
                    o.status = ST_OVERFLOW;
                else
                begin
                    rear_idx++;
                    words[rear_idx] = r.value;
                end
                due_rsp.insert(due_rsp.size(), o);
            end
            ACT_PUSH_FRONT:
            begin
                if (front_idx <= 0)
                    o.status = ST_OVERFLOW;
                else
                begin
                    front_idx--;
                    words[front_idx] = r.value;
                end
                due_rsp.insert(due_rsp.size(), o);
            end
            ACT_POP_FRONT:
            begin
                if (front_idx > rear_idx)
                    o.status = ST_UNDERFLOW;
                else
                    front_idx++;
                due_rsp.insert(due_rsp.size(), o);
            end
            ACT_POP_BACK:
            begin
                if (front_idx > rear_idx)
                    o.status = ST_UNDERFLOW;
                else
                    rear_idx--;
                due_rsp.insert(due_rsp.size(), o);
            end
            ACT_DUMP:
            begin
                if (front_idx > rear_idx)
                begin
                    o.status = ST_EMPTY;
                    due_rsp.insert(due_rsp.size(), o);
                end
                else
                begin
                    for (int i = front_idx; i <= rear_idx; i++)
                    begin
                        o.element = words[i];
                        o.last    = (i == rear_idx);
                        due_rsp.insert(due_rsp.size(), o);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void add_row(input logic [2:0] act, input logic [DATA_W-1:0] val,
                                    input bit fixed, input logic [1:0] st);
        row_t row;
        row.req.action  = act;
        row.req.value   = val;
        row.fixed       = fixed;
        row.rsp.status  = st;
        row.rsp.element = '0;
        row.rsp.last    = 1'b1;
        rows.insert(rows.size(), row);
    endfunction

    task automatic send(input logic [2:0] act, input logic [DATA_W-1:0] val,
                        input bit fixed, input rsp_t typed);
        req_t r;
        r.action = act;
        r.value  = val;
        while ($urandom_range(99) < send_idle)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= r;
        row_fixed = fixed;
        row_rsp   = typed;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending until every pending result is back
    task automatic settle();
        cmd_valid <= 1'b0;
        row_fixed = 1'b0;
        do
            @(negedge clk);
        while (due_rsp.size() != 0);
    endtask

    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < recv_idle);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: status %0d element %0d last %0d",
                                 rsp_data.status, rsp_data.element, rsp_data.last);
                end
                else
                begin
                    want = due_rsp[0];
                    due_rsp.delete(0);
                    if (want.status !== rsp_data.status || want.element !== rsp_data.element
                        || want.last !== rsp_data.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: expected status %0d element %0d last %0d, %s",
                                     want.status, want.element, want.last,
                                     $sformatf("got status %0d element %0d last %0d",
                                               rsp_data.status, rsp_data.element,
                                               rsp_data.last));
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                step_deque(cmd_data);
                if (row_fixed && due_rsp.size() != 0)
                    due_rsp[due_rsp.size() - 1] = row_rsp;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int          len;
        logic [2:0]  act;
        front_idx = DEPTH / 2 + 1;
        rear_idx  = DEPTH / 2;
        foreach (words[i])
            words[i] = '0;

        // empty queue, extremes of value, ignored codes, both ends
        add_row(ACT_POP_FRONT,  32'h0000_0000, 1'b1, ST_UNDERFLOW);
        add_row(ACT_POP_BACK,   32'h0000_0000, 1'b1, ST_UNDERFLOW);
        add_row(ACT_DUMP,       32'h0000_0000, 1'b1, ST_EMPTY);
        add_row(ACT_RSVD_A,     32'hffff_ffff, 1'b0, ST_OK);
        add_row(ACT_PUSH_BACK,  32'h7fff_ffff, 1'b1, ST_OK);
        add_row(ACT_PUSH_FRONT, 32'h8000_0000, 1'b1, ST_OK);
        add_row(ACT_PUSH_BACK,  32'hffff_ffff, 1'b1, ST_OK);
        add_row(ACT_PUSH_FRONT, 32'h0000_0000, 1'b1, ST_OK);
        add_row(ACT_DUMP,       32'h0000_0000, 1'b0, ST_OK);
        add_row(ACT_RSVD_B,     32'h5a5a_5a5a, 1'b0, ST_OK);
        add_row(ACT_RSVD_C,     32'ha5a5_a5a5, 1'b0, ST_OK);
        add_row(ACT_POP_FRONT,  32'hffff_ffff, 1'b1, ST_OK);
        add_row(ACT_POP_BACK,   32'hffff_ffff, 1'b1, ST_OK);
        add_row(ACT_DUMP,       32'hffff_ffff, 1'b0, ST_OK);
        add_row(ACT_PUSH_FRONT, 32'h1234_5678, 1'b1, ST_OK);
        add_row(ACT_DUMP,       32'h0000_0000, 1'b0, ST_OK);
        add_row(ACT_POP_BACK,   32'h0000_0000, 1'b1, ST_OK);
        add_row(ACT_POP_BACK,   32'h0000_0000, 1'b1, ST_OK);
        add_row(ACT_POP_BACK,   32'h0000_0000, 1'b1, ST_OK);
        add_row(ACT_POP_FRONT,  32'h0000_0000, 1'b1, ST_UNDERFLOW);
        add_row(ACT_DUMP,       32'h0000_0000, 1'b1, ST_EMPTY);

        send_idle = 31;
        recv_idle = 65;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send(rows[i].req.action, rows[i].req.value, rows[i].fixed, rows[i].rsp);
        settle();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 31;
                    recv_idle = 65;
                end
                1:
                begin
                    send_idle = 65;
                    recv_idle = 31;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                case ($urandom_range(9))
                    0, 1:
                    begin
                        len = $urandom_range(40, 5);
                        repeat (len) send(ACT_PUSH_BACK, $urandom, 1'b0, '0);
                        sent += len;
                    end
                    2, 3:
                    begin
                        len = $urandom_range(40, 5);
                        repeat (len) send(ACT_PUSH_FRONT, $urandom, 1'b0, '0);
                        sent += len;
                    end
                    4:
                    begin
                        len = $urandom_range(40, 5);
                        repeat (len)
                            send($urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK,
                                 $urandom, 1'b0, '0);
                        sent += len;
                    end
                    5, 6:
                    begin
                        len = $urandom_range(8, 1);
                        repeat (len)
                        begin
                            act = 3'($urandom_range(ACT_POP_BACK, ACT_PUSH_BACK));
                            send(act, $urandom, 1'b0, '0);
                        end
                        sent += len;
                    end
                    7, 8:
                    begin
                        send(ACT_DUMP, $urandom, 1'b0, '0);
                        sent++;
                    end
                    default:
                    begin
                        act = 3'($urandom_range(ACT_RSVD_C, ACT_PUSH_BACK));
                        send(act, $urandom, 1'b0, '0);
                        if (act <= ACT_DUMP)
                            sent++;
                    end
                endcase
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        mismatches += due_rsp.size();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
